// ===== design/byte_pattern_find_replace_assert.svh =====
// Assertion macros shared by the pattern search and replace modules.
// Needs i_clk and i_rst_n in the scope of each use.
`ifndef BYTE_PATTERN_FIND_REPLACE_ASSERT_SVH
`define BYTE_PATTERN_FIND_REPLACE_ASSERT_SVH

// Property checked at every clock edge outside reset
`define BPFR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Condition that must hold in the cycle after a trigger
`define BPFR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/bpfr_pkg.sv =====
// Shared constants and types for the byte pattern search and replace block.
// No dependencies.
`default_nettype none

package bpfr_pkg;

    localparam int MAX_PATTERN = 8;
    localparam int QDEPTH      = MAX_PATTERN + 1;
    localparam int FILL_W      = 4;
    localparam int CFG_IDX_W   = 2;
    localparam int PAT_W       = 8 * MAX_PATTERN;

    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SEARCH_PATTERN  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REPLACE_PATTERN = 2'd2;

    typedef logic [FILL_W-1:0] t_fill;
    typedef logic [7:0]        t_byte;
    typedef logic [15:0]       t_total;

    // Result run produced by one input beat
    typedef struct packed {
        logic [QDEPTH-1:0][7:0] bytes;
        logic [QDEPTH-1:0]      rep;
        t_fill                  cnt;
        logic                   fin;
        t_total                 total;
    } t_load;

    // Configuration seen by the window logic
    typedef struct packed {
        t_fill             len;
        logic [PAT_W-1:0]  search;
        logic [PAT_W-1:0]  replace;
    } t_cfg;

endpackage

`default_nettype wire

// ===== design/bpfr_ifs.sv =====
// Valid/ready channel interfaces: input bytes, result bytes, register writes.
// Depends on bpfr_pkg.
`default_nettype none

interface bpfr_in_if;
    import bpfr_pkg::*;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       final_byte;
    modport source (output valid, output data_byte, output final_byte, input ready);
    modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

interface bpfr_out_if;
    import bpfr_pkg::*;
    logic        valid;
    logic        ready;
    logic [7:0]  out_byte;
    logic        replaced;
    logic        run_last;
    logic        buffer_end;
    logic [15:0] match_total;
    modport source (output valid, output out_byte, output replaced, output run_last,
                    output buffer_end, output match_total, input ready);
    modport sink   (input valid, input out_byte, input replaced, input run_last,
                    input buffer_end, input match_total, output ready);
endinterface

interface bpfr_cfg_if;
    import bpfr_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [63:0]          data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== design/bpfr_window.sv =====
// Pending byte window, pattern compare and match counter; builds the result run
// for each accepted beat. Depends on bpfr_pkg and the assertion macro header.
`default_nettype none

module bpfr_window (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic [7:0]       i_data_byte,
    input  logic             i_final_byte,
    input  bpfr_pkg::t_cfg   i_cfg,
    output bpfr_pkg::t_load  o_load
);
    import bpfr_pkg::*;

    t_byte  r_win [MAX_PATTERN];
    t_fill  r_fill;
    t_total r_count;

    t_byte  n_win [MAX_PATTERN];
    t_fill  n_fill;
    t_total n_count;

    t_byte  w_all [QDEPTH];
    t_fill  len;
    t_fill  m;
    t_fill  e;
    logic   full;
    logic   hit;
    t_fill  idx;
    t_fill  ridx;
    t_fill  sidx;
    t_total total;

    // Clamp the configured length into 1..MAX_PATTERN
    always_comb begin
        len = i_cfg.len;
        if (len == '0) begin
            len = FILL_W'(1);
        end else if (len > FILL_W'(MAX_PATTERN)) begin
            len = FILL_W'(MAX_PATTERN);
        end
    end

    // Window with the new byte appended
    always_comb begin
        for (int i = 0; i < MAX_PATTERN; i++) begin
            if (FILL_W'(i) < r_fill) begin
                w_all[i] = r_win[i];
            end else if (FILL_W'(i) == r_fill) begin
                w_all[i] = i_data_byte;
            end else begin
                w_all[i] = '0;
            end
        end
        w_all[MAX_PATTERN] = (r_fill == FILL_W'(MAX_PATTERN)) ? i_data_byte : '0;
    end

    // Excess bytes ahead of a full-length window
    assign m    = r_fill + FILL_W'(1);
    assign full = (m >= len);
    assign e    = full ? (m - len) : '0;

    // Compare the last len bytes against the search pattern
    always_comb begin
        hit = full;
        idx = '0;
        for (int i = 0; i < MAX_PATTERN; i++) begin
            if (FILL_W'(i) < len) begin
                idx = e + FILL_W'(i);
                if (idx < FILL_W'(QDEPTH)) begin
                    if (w_all[idx] != i_cfg.search[8*i +: 8]) begin
                        hit = 1'b0;
                    end
                end
            end
        end
    end

    // Saturating match count including this beat
    assign total = (hit && r_count != '1) ? r_count + 16'd1 : r_count;

    // Build the result run
    always_comb begin
        ridx = '0;
        for (int k = 0; k < QDEPTH; k++) begin
            if (hit && FILL_W'(k) >= e) begin
                ridx           = FILL_W'(k) - e;
                o_load.bytes[k] = i_cfg.replace[{ridx[2:0], 3'b000} +: 8];
                o_load.rep[k]   = 1'b1;
            end else begin
                o_load.bytes[k] = w_all[k];
                o_load.rep[k]   = 1'b0;
            end
        end
        if (hit || i_final_byte) begin
            o_load.cnt = m;
        end else if (full) begin
            o_load.cnt = e + FILL_W'(1);
        end else begin
            o_load.cnt = '0;
        end
        o_load.fin   = i_final_byte;
        o_load.total = total;
    end

    // Next window contents
    always_comb begin
        sidx = '0;
        for (int i = 0; i < MAX_PATTERN; i++) begin
            n_win[i] = '0;
        end
        if (hit || i_final_byte) begin
            n_fill = '0;
        end else if (full) begin
            n_fill = len - FILL_W'(1);
            for (int i = 0; i < MAX_PATTERN; i++) begin
                sidx = FILL_W'(i) + e + FILL_W'(1);
                if (FILL_W'(i) < n_fill && sidx < FILL_W'(QDEPTH)) begin
                    n_win[i] = w_all[sidx];
                end
            end
        end else begin
            n_fill = m;
            for (int i = 0; i < MAX_PATTERN; i++) begin
                n_win[i] = w_all[i];
            end
        end
        n_count = i_final_byte ? '0 : total;
    end

    // Advance the window state on each accepted beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill  <= '0;
            r_count <= '0;
        end else if (i_accept) begin
            r_fill  <= n_fill;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_win <= n_win;
        end
    end

`include "byte_pattern_find_replace_assert.svh"

    `BPFR_ASSERT(a_fill_bound, r_fill <= FILL_W'(MAX_PATTERN), "window fill above maximum")
    `BPFR_ASSERT_NEXT(a_flush_clear, i_accept && i_final_byte, r_fill == '0 && r_count == '0, "window or count not cleared after buffer end")
    `BPFR_ASSERT_NEXT(a_fill_short, i_accept && !i_final_byte, r_fill < $past(len), "window left at or above pattern length")

endmodule

`default_nettype wire

// ===== design/bpfr_serial.sv =====
// Result run queue and output register: hands out one result beat per cycle while the output is ready.
// Depends on bpfr_pkg, bpfr_ifs and the assertion macro header.
`default_nettype none

module bpfr_serial (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  bpfr_pkg::t_load  i_load,
    input  logic             i_accept,
    output logic             o_load_ready,
    bpfr_out_if.source       o_out
);
    import bpfr_pkg::*;

    t_load       r_q;
    t_fill       r_idx;
    logic        r_ovalid;
    logic [7:0]  r_obyte;
    logic        r_orep;
    logic        r_olast;
    logic        r_oend;
    t_total      r_ototal;

    logic q_has;
    logic q_last;
    logic adv;

    // Queue status and advance
    assign q_has        = (r_idx < r_q.cnt);
    assign q_last       = (r_idx == r_q.cnt - FILL_W'(1));
    assign adv          = q_has && (!r_ovalid || o_out.ready);
    assign o_load_ready = !q_has || (adv && q_last);

    // Load a new run or step through the current one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q.cnt <= '0;
            r_idx   <= '0;
        end else if (i_accept) begin
            r_q   <= i_load;
            r_idx <= '0;
        end else if (adv) begin
            r_idx <= r_idx + FILL_W'(1);
        end
    end

    // Output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (adv) begin
            r_ovalid <= 1'b1;
        end else if (o_out.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    // Output register payload
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_obyte  <= r_q.bytes[r_idx];
            r_orep   <= r_q.rep[r_idx];
            r_olast  <= q_last;
            r_oend   <= q_last && r_q.fin;
            r_ototal <= r_q.total;
        end
    end

    assign o_out.valid       = r_ovalid;
    assign o_out.out_byte    = r_obyte;
    assign o_out.replaced    = r_orep;
    assign o_out.run_last    = r_olast;
    assign o_out.buffer_end  = r_oend;
    assign o_out.match_total = r_ototal;

`include "byte_pattern_find_replace_assert.svh"

    `BPFR_ASSERT(a_idx_bound, r_idx <= r_q.cnt, "queue read index past run length")
    `BPFR_ASSERT(a_cnt_bound, r_q.cnt <= FILL_W'(QDEPTH), "run length above queue depth")
    `BPFR_ASSERT(a_end_last, !r_ovalid || !r_oend || r_olast, "buffer end not on last beat of run")

endmodule

`default_nettype wire

// ===== design/byte_pattern_find_replace.sv =====
// Streaming fixed-pattern search and replace, one byte beat in, result beats out.
// An accepted beat's run is registered in the queue, then its first result in the output register.
// Throughput: one beat per cycle while each beat yields at most one result and the output
// port takes it; a beat yielding n results (up to 8) holds the input until its last result moves out.
// Reset (synchronous, active low) empties window, queue and count; length 1, patterns 0.
// Depends on bpfr_pkg, bpfr_ifs, bpfr_window and bpfr_serial.
`default_nettype none

module byte_pattern_find_replace (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bpfr_in_if.sink     i_in,
    bpfr_out_if.source  o_out,
    bpfr_cfg_if.sink    i_cfg
);
    import bpfr_pkg::*;

    t_fill            r_len;
    logic [PAT_W-1:0] r_search;
    logic [PAT_W-1:0] r_replace;

    t_cfg  cfg;
    t_load load;
    logic  load_ready;
    logic  accept;

    // Register writes are always taken
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len     <= FILL_W'(1);
            r_search  <= '0;
            r_replace <= '0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_PATTERN_LENGTH:  r_len     <= i_cfg.data[FILL_W-1:0];
                REG_SEARCH_PATTERN:  r_search  <= i_cfg.data[PAT_W-1:0];
                REG_REPLACE_PATTERN: r_replace <= i_cfg.data[PAT_W-1:0];
                default: ;
            endcase
        end
    end

    assign cfg.len     = r_len;
    assign cfg.search  = r_search;
    assign cfg.replace = r_replace;

    // Input handshake
    assign i_in.ready = load_ready;
    assign accept     = i_in.valid && load_ready;

    bpfr_window u_window (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_data_byte  (i_in.data_byte),
        .i_final_byte (i_in.final_byte),
        .i_cfg        (cfg),
        .o_load       (load)
    );

    bpfr_serial u_serial (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (load),
        .i_accept     (accept),
        .o_load_ready (load_ready),
        .o_out        (o_out)
    );

endmodule

`default_nettype wire

// ===== sim/byte_pattern_find_replace_test.sv =====
// Self-checking bench for byte_pattern_find_replace: random-stalled byte beats in,
// patched result beats checked against a behavioral window model kept here.
// Depends on bpfr_pkg, bpfr_ifs and the block itself.
`default_nettype none

module byte_pattern_find_replace_test;
    import bpfr_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 8;
    localparam int ITEMS_PER_MODE = 22;

    typedef struct {
        t_byte data;
        logic  fin;
    } t_byte_item;

    typedef struct {
        t_byte  data;
        logic   rep;
        logic   last;
        logic   fin;
        t_total total;
    } t_patch_beat;

    logic i_clk;
    logic i_rst_n;

    bpfr_in_if  byte_in ();
    bpfr_out_if patch_out ();
    bpfr_cfg_if reg_wr ();

    byte_pattern_find_replace u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (byte_in),
        .o_out   (patch_out),
        .i_cfg   (reg_wr)
    );

    // Register copies, updated when a write beat is accepted
    t_fill       pat_len       = 4'd1;
    logic [63:0] search_bytes  = '0;
    logic [63:0] replace_bytes = '0;

    // Window model
    t_byte  held_bytes[$];
    t_total buffer_matches = '0;

    t_byte_item  byte_q[$];
    t_patch_beat patched_q[$];

    int items_pushed = 0;
    int beats_taken  = 0;
    int error_count  = 0;
    int cycle_count  = 0;
    int in_idle_pct  = 0;
    int out_stall_pct = 0;

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    function automatic int eff_len(input t_fill l);
        if (l == 0)
            return 1;
        if (l > MAX_PATTERN)
            return MAX_PATTERN;
        return int'(l);
    endfunction

    // Work out the result beats of one accepted byte beat and queue them
    task automatic patch_byte(input t_byte b, input logic fin);
        int          len;
        int          i;
        bit          hit;
        t_byte       emit_b[$];
        bit          emit_r[$];
        t_patch_beat pb;
        len = eff_len(pat_len);
        if (held_bytes.size() >= MAX_PATTERN) begin
            emit_b = {emit_b, held_bytes.pop_front()};
            emit_r = {emit_r, 1'b0};
        end
        held_bytes = {held_bytes, b};
        // Shed bytes beyond a lowered length unchanged
        while (held_bytes.size() > len) begin
            emit_b = {emit_b, held_bytes.pop_front()};
            emit_r = {emit_r, 1'b0};
        end
        if (held_bytes.size() == len) begin
            hit = 1'b1;
            for (i = 0; i < len; i++)
                if (held_bytes[i] != search_bytes[8*i +: 8])
                    hit = 1'b0;
            if (hit) begin
                for (i = 0; i < len; i++) begin
                    emit_b = {emit_b, t_byte'(replace_bytes[8*i +: 8])};
                    emit_r = {emit_r, 1'b1};
                end
                held_bytes.delete();
                if (buffer_matches != 16'hFFFF)
                    buffer_matches++;
            end else begin
                emit_b = {emit_b, held_bytes.pop_front()};
                emit_r = {emit_r, 1'b0};
            end
        end
        // Flush the window on the final byte
        if (fin) begin
            while (held_bytes.size() > 0) begin
                emit_b = {emit_b, held_bytes.pop_front()};
                emit_r = {emit_r, 1'b0};
            end
        end
        foreach (emit_b[k]) begin
            pb.data  = emit_b[k];
            pb.rep   = emit_r[k];
            pb.last  = (k == emit_b.size() - 1);
            pb.fin   = fin && pb.last;
            pb.total = buffer_matches;
            patched_q = {patched_q, pb};
        end
        if (fin) begin
            held_bytes.delete();
            buffer_matches = '0;
        end
    endtask

    function automatic void check_field(input string name, input longint want,
                                        input longint got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            error_count++;
        end
    endfunction

    // Byte driver: present queued beats, idle at random, predict on each accepted beat
    always @(posedge i_clk) begin : byte_driver
        t_byte_item nxt;
        if (!i_rst_n) begin
            byte_in.valid <= 1'b0;
        end else begin
            if (byte_in.valid && byte_in.ready) begin
                patch_byte(byte_in.data_byte, byte_in.final_byte);
                beats_taken++;
            end
            if (!byte_in.valid || byte_in.ready) begin
                if (byte_q.size() > 0 && $urandom_range(99) >= in_idle_pct) begin
                    nxt = byte_q.pop_front();
                    byte_in.valid      <= 1'b1;
                    byte_in.data_byte  <= nxt.data;
                    byte_in.final_byte <= nxt.fin;
                end else begin
                    byte_in.valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: stall at random, compare each accepted beat with the oldest expected
    always @(posedge i_clk) begin : result_monitor
        t_patch_beat want;
        if (!i_rst_n) begin
            patch_out.ready <= 1'b0;
        end else begin
            if (patch_out.valid && patch_out.ready) begin
                if (patched_q.size() == 0) begin
                    $display("%0t: unexpected result beat, expected none, actual byte %02h",
                             $time, patch_out.out_byte);
                    error_count++;
                end else begin
                    want = patched_q.pop_front();
                    check_field("out_byte", want.data, patch_out.out_byte);
                    check_field("replaced", want.rep, patch_out.replaced);
                    check_field("run_last", want.last, patch_out.run_last);
                    check_field("buffer_end", want.fin, patch_out.buffer_end);
                    check_field("match_total", want.total, patch_out.match_total);
                end
            end
            patch_out.ready <= ($urandom_range(99) >= out_stall_pct);
        end
    end

    // Give up on a hung run
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic push_item(input t_byte b, input logic fin);
        t_byte_item it;
        it.data = b;
        it.fin  = fin;
        byte_q = {byte_q, it};
        items_pushed++;
    endtask

    // Write one register and update the local copy on its beat
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
        @(posedge i_clk);
        reg_wr.valid <= 1'b1;
        reg_wr.index <= idx;
        reg_wr.data  <= val;
        do @(posedge i_clk); while (!reg_wr.ready);
        reg_wr.valid <= 1'b0;
        case (idx)
            REG_PATTERN_LENGTH:  pat_len = val[3:0];
            REG_SEARCH_PATTERN:  search_bytes = val;
            REG_REPLACE_PATTERN: replace_bytes = val;
            default: ;
        endcase
    endtask

    // Length write with junk in the unused upper bits
    task automatic set_length(input t_fill l);
        logic [63:0] val;
        val = {$urandom, $urandom};
        val[3:0] = l;
        write_reg(REG_PATTERN_LENGTH, val);
    endtask

    // Hold until every byte is taken and every result has arrived, then let the block settle
    task automatic wait_quiet();
        do @(posedge i_clk); while (beats_taken != items_pushed || patched_q.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // One random setting followed by pattern-heavy byte runs
    task automatic random_phase(input int n_items);
        t_fill       l;
        logic [63:0] val;
        int          len;
        int          added;
        int          pick;
        int          part;
        int          j;
        bit          fin;
        case ($urandom_range(4))
            0: l = 4'd1;
            1: l = 4'd8;
            2: l = $urandom_range(1) ? 4'd0 : 4'(15 - $urandom_range(6));
            default: l = 4'($urandom_range(1, 8));
        endcase
        set_length(l);
        if ($urandom_range(3) != 0) begin
            val = {$urandom, $urandom};
            write_reg(REG_SEARCH_PATTERN, val);
        end
        if ($urandom_range(3) != 0) begin
            val = {$urandom, $urandom};
            write_reg(REG_REPLACE_PATTERN, val);
        end
        len = eff_len(pat_len);
        added = 0;
        while (added < n_items) begin
            fin = ($urandom_range(5) == 0);
            pick = $urandom_range(9);
            if (pick < 5) begin
                // whole pattern
                for (j = 0; j < len; j++)
                    push_item(search_bytes[8*j +: 8], fin && j == len - 1);
                added += len;
            end else if (pick < 7 && len > 1) begin
                // broken pattern: a prefix, then any byte
                part = $urandom_range(1, len - 1);
                for (j = 0; j < part; j++)
                    push_item(search_bytes[8*j +: 8], 1'b0);
                push_item(8'($urandom), fin);
                added += part + 1;
            end else begin
                j = $urandom_range(len - 1);
                push_item($urandom_range(1) ? search_bytes[8*j +: 8] : 8'($urandom), fin);
                added++;
            end
        end
        wait_quiet();
    endtask

    initial begin : stimulus
        int start;
        int m;
        logic [63:0] pat8;
        i_rst_n              = 1'b0;
        byte_in.valid        = 1'b0;
        byte_in.data_byte    = '0;
        byte_in.final_byte   = 1'b0;
        patch_out.ready      = 1'b0;
        reg_wr.valid         = 1'b0;
        reg_wr.index         = REG_PATTERN_LENGTH;
        reg_wr.data          = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        in_idle_pct   = 32;
        out_stall_pct = 87;

        // Reset settings: length 1, zero pattern replaced by zero
        push_item(8'h00, 1'b0);
        push_item(8'hFF, 1'b1);
        wait_quiet();

        // Three-byte pattern with a false start before the match
        set_length(4'd3);
        write_reg(REG_SEARCH_PATTERN, {$urandom, 8'($urandom), 24'h332211});
        write_reg(REG_REPLACE_PATTERN, {$urandom, 8'($urandom), 24'h00FFEE});
        push_item(8'h11, 1'b0);
        push_item(8'h22, 1'b0);
        push_item(8'h11, 1'b0);
        push_item(8'h22, 1'b0);
        push_item(8'h33, 1'b0);
        push_item(8'h00, 1'b0);
        push_item(8'hFF, 1'b1);
        wait_quiet();

        // Zero length acts as one
        set_length(4'd0);
        write_reg(REG_SEARCH_PATTERN, {$urandom, 24'($urandom), 8'h5A});
        write_reg(REG_REPLACE_PATTERN, {$urandom, 24'($urandom), 8'hA5});
        push_item(8'h5A, 1'b0);
        push_item(8'h00, 1'b1);
        wait_quiet();

        // Oversize length acts as eight; leave bytes pending, then lower the length
        pat8 = {$urandom, $urandom};
        set_length(4'd15);
        write_reg(REG_SEARCH_PATTERN, pat8);
        write_reg(REG_REPLACE_PATTERN, {$urandom, $urandom});
        for (m = 0; m < 8; m++)
            push_item(pat8[8*m +: 8], 1'b0);
        for (m = 0; m < 5; m++)
            push_item(pat8[8*m +: 8], 1'b0);
        wait_quiet();
        set_length(4'd2);
        push_item(pat8[7:0], 1'b0);
        push_item(pat8[15:8], 1'b1);
        wait_quiet();

        // Random runs under three idle mixes
        for (m = 0; m < 3; m++) begin
            in_idle_pct   = (m == 0) ? 32 : (m == 1) ? 87 : 0;
            out_stall_pct = (m == 0) ? 87 : (m == 1) ? 32 : 0;
            start = items_pushed;
            while (items_pushed - start < ITEMS_PER_MODE)
                random_phase($urandom_range(8, 16));
        end

        wait_quiet();
        repeat (16) @(posedge i_clk);
        if (error_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

`default_nettype wire
